[rtl/hnms_pkg.sv]
package hnms_pkg;

    localparam int COORD_W = 16;
    localparam int SCORE_W = 16;
    localparam int THR_W   = 17;
    localparam int CNT_W   = 7;

    localparam logic [1:0] REG_IOU_THRESHOLD   = 2'd0;
    localparam logic [1:0] REG_MAX_PICKS       = 2'd1;
    localparam logic [1:0] REG_CANDIDATE_LIMIT = 2'd2;

    localparam logic [THR_W-1:0] THR_RESET   = 17'd29491;
    localparam logic [CNT_W-1:0] PICKS_RESET = 7'd0;
    localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd64;

    // x_min sits in the lowest bits, as on the stream
    typedef struct packed {
        logic [COORD_W-1:0] y_max;
        logic [COORD_W-1:0] x_max;
        logic [COORD_W-1:0] y_min;
        logic [COORD_W-1:0] x_min;
    } box_t;

endpackage

[rtl/hnms_ram.sv]
module hnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/hnms_iou.sv]
// IoU keep test with registered areas: overlap<<16 <= thr*(union+eps).
module hnms_iou
    import hnms_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic              clk,
    input  logic [4*CW-1:0]   box_a,
    input  logic [4*CW-1:0]   box_b,
    input  logic [THR_W-1:0]  thr,
    output logic              keep
);

    localparam int AW = 2 * CW;
    localparam logic [AW+1:0] EPS =
        (AW + 2)'(((64'd1 << AW) + 64'd50000) / 64'd100000);

    logic [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic [CW-1:0] ox0, oy0, ox1, oy1;
    logic [CW-1:0] aw, ah, bw, bh, ow, oh;
    logic [AW-1:0] area_a_reg, area_b_reg, ov_reg;
    logic [AW+1:0] den;
    logic [AW+THR_W+2:0] rhs, lhs;

    assign {ay1, ax1, ay0, ax0} = box_a;
    assign {by1, bx1, by0, bx0} = box_b;
    assign ox0 = (ax0 > bx0) ? ax0 : bx0;
    assign oy0 = (ay0 > by0) ? ay0 : by0;
    assign ox1 = (ax1 < bx1) ? ax1 : bx1;
    assign oy1 = (ay1 < by1) ? ay1 : by1;
    assign aw = (ax1 > ax0) ? ax1 - ax0 : '0;
    assign ah = (ay1 > ay0) ? ay1 - ay0 : '0;
    assign bw = (bx1 > bx0) ? bx1 - bx0 : '0;
    assign bh = (by1 > by0) ? by1 - by0 : '0;
    assign ow = (ox1 > ox0) ? ox1 - ox0 : '0;
    assign oh = (oy1 > oy0) ? oy1 - oy0 : '0;

    always_ff @(posedge clk)
    begin
        area_a_reg <= aw * ah;
        area_b_reg <= bw * bh;
        ov_reg     <= ow * oh;
    end

    assign den = {2'b0, area_a_reg} + {2'b0, area_b_reg} - {2'b0, ov_reg} + EPS;
    assign rhs = (AW + THR_W + 3)'(den) * (AW + THR_W + 3)'(thr);
    assign lhs = (AW + THR_W + 3)'(ov_reg) << 16;
    assign keep = (lhs <= rhs);

endmodule

[rtl/hard_non_maximum_suppression_unit.sv]
// Channel  Dir  Handshake                 Payload
// s_axis   in   s_axis_tvalid/tready      tdata boxes+score, tlast set_end
// m_axis   out  m_axis_tvalid/tready      tdata index+box+score, tlast last_pick
// cfg      in   cfg_valid/cfg_ready       cfg_index, cfg_data
// Loading takes one box per cycle. On tlast each box is ranked against the
// whole store. A pick then reads the order list and the store (a dropped
// candidate is skipped), then sweeps every later candidate through IoU,
// all on one IoU datapath and one store read port. A pick is held until
// the next one is found or the set ends, and waits on a full output.
// Input stalls until the last pick is taken; rst_n clears control, not the store.
module hard_non_maximum_suppression_unit
    import hnms_pkg::*;
#(
    parameter int MAX_BOXES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // x_min, y_min, x_max, y_max, score
    input  logic        s_axis_tlast,   // set_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // box_index, out_x_min, out_y_min,
                                        // out_x_max, out_y_max, out_score
    output logic        m_axis_tlast,   // last_pick
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int IW = $clog2(MAX_BOXES);
    localparam int NW = IW + 1;
    localparam int BW = 4 * COORD_W + SCORE_W;

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_RI    = 11'b00000000010,
        S_RJ    = 11'b00000000100,
        S_RCMP  = 11'b00000001000,
        S_PSEL  = 11'b00000010000,
        S_PRD   = 11'b00000100000,
        S_EMIT  = 11'b00001000000,
        S_SJ    = 11'b00010000000,
        S_SRD   = 11'b00100000000,
        S_SCMP  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [THR_W-1:0] thr_reg;
    logic [CNT_W-1:0] picks_reg, limit_reg;

    logic [NW-1:0] count_reg, count_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next, cur_reg, cur_next;
    logic [NW-1:0] rank_reg, rank_next, ncand_reg, ncand_next;
    logic [CNT_W-1:0] picked_reg, picked_next;
    logic [MAX_BOXES-1:0] alive_reg, alive_next;
    logic [2:0] wait_reg, wait_next;
    logic [BW-1:0] hold_reg, hold_next;
    logic out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic pend_reg, pend_next;
    logic [IW-1:0] out_idx_reg, out_idx_next;
    logic [BW-1:0] out_box_reg, out_box_next;

    // box store, order list
    logic          box_we, ord_we;
    logic [IW-1:0] box_raddr, box_waddr, ord_raddr, ord_waddr;
    logic [BW-1:0] box_rdata, box_wdata;
    logic [IW-1:0] ord_rdata, ord_wdata;

    hnms_ram #(.WIDTH(BW), .DEPTH(MAX_BOXES)) u_box (
        .clk(clk), .we(box_we), .waddr(box_waddr), .wdata(box_wdata),
        .raddr(box_raddr), .rdata(box_rdata)
    );

    hnms_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_ord (
        .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(ord_wdata),
        .raddr(ord_raddr), .rdata(ord_rdata)
    );

    logic keep;
    hnms_iou #(.CW(COORD_W)) u_iou (
        .clk(clk), .box_a(box_rdata[4*COORD_W-1:0]),
        .box_b(hold_reg[4*COORD_W-1:0]), .thr(thr_reg), .keep(keep)
    );

    wire [SCORE_W-1:0] sj = box_rdata[BW-1 -: SCORE_W];
    wire [SCORE_W-1:0] si = hold_reg[BW-1 -: SCORE_W];
    // hold_reg holds box i; the index of box i is i_reg
    wire above = (sj > si) || ((sj == si) && (j_reg > i_reg));
    wire accept_in = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b0, out_box_reg, (6)'(out_idx_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg   <= THR_RESET;
            picks_reg <= PICKS_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IOU_THRESHOLD:   thr_reg   <= cfg_data;
                REG_MAX_PICKS:       picks_reg <= cfg_data[CNT_W-1:0];
                REG_CANDIDATE_LIMIT: limit_reg <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        rank_next      = rank_reg;
        ncand_next     = ncand_reg;
        picked_next    = picked_reg;
        alive_next     = alive_reg;
        wait_next      = wait_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        pend_next      = pend_reg;
        out_idx_next   = out_idx_reg;
        out_box_next   = out_box_reg;
        box_we    = 1'b0;
        box_waddr = count_reg[IW-1:0];
        box_wdata = s_axis_tdata;
        box_raddr = j_reg;
        ord_we    = 1'b0;
        ord_waddr = rank_reg[IW-1:0];
        ord_wdata = i_reg;
        ord_raddr = k_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_LOAD:
            begin
                if (accept_in)
                begin
                    if (count_reg < NW'(MAX_BOXES))
                    begin
                        box_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (s_axis_tlast)
                    begin
                        i_next     = '0;
                        ncand_next = '0;
                        alive_next = '0;
                        state_next = S_RI;
                    end
                end
            end
            S_RI:
            begin
                // read box i into hold
                box_raddr = i_reg;
                j_next    = '0;
                rank_next = '0;
                wait_next = 3'd0;
                state_next = S_RJ;
            end
            S_RJ:
            begin
                box_raddr = i_reg;
                if (wait_reg == 3'd0)
                begin
                    wait_next = 3'd1;
                end
                else
                begin
                    hold_next  = box_rdata;
                    box_raddr  = j_reg;
                    state_next = S_RCMP;
                end
            end
            S_RCMP:
            begin
                if ((j_reg != i_reg) && above)
                    rank_next = rank_reg + 1'b1;
                if ({1'b0, j_reg} + 1'b1 >= count_reg)
                begin
                    state_next = S_PSEL;
                    wait_next  = 3'd0;
                    if ({{CNT_W{1'b0}}, rank_next} < {{NW{1'b0}}, limit_reg})
                    begin
                        ord_we    = 1'b1;
                        ord_waddr = rank_next[IW-1:0];
                        alive_next[i_reg] = 1'b1;
                        ncand_next = ncand_reg + 1'b1;
                    end
                end
                else
                begin
                    j_next    = j_reg + 1'b1;
                    box_raddr = j_reg + 1'b1;
                end
            end
            S_PSEL:
            begin
                // next i, or start picking
                if ({1'b0, i_reg} + 1'b1 < count_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_RI;
                end
                else
                begin
                    k_next      = '0;
                    picked_next = '0;
                    state_next  = S_PRD;
                    wait_next   = 3'd0;
                    if (ncand_reg == '0)
                        state_next = S_DONE;
                end
            end
            S_PRD:
            begin
                // order[k] -> box[cur]
                ord_raddr = k_reg;
                if (wait_reg == 3'd0)
                    wait_next = 3'd1;
                else if (wait_reg == 3'd1)
                begin
                    cur_next  = ord_rdata;
                    box_raddr = ord_rdata;
                    wait_next = 3'd2;
                    if (!alive_reg[ord_rdata])
                    begin
                        wait_next = 3'd0;
                        if ({1'b0, k_reg} + 1'b1 >= ncand_reg)
                            state_next = S_DONE;
                        else
                            k_next = k_reg + 1'b1;
                    end
                    else if (pend_reg)
                    begin
                        // another pick follows: release the held word
                        out_valid_next = 1'b1;
                        out_last_next  = 1'b0;
                        pend_next      = 1'b0;
                    end
                end
                else
                begin
                    box_raddr = cur_reg;
                    if (wait_reg == 3'd2)
                        wait_next = 3'd3;
                    else if (!out_valid_reg)
                    begin
                        hold_next  = box_rdata;
                        alive_next[cur_reg] = 1'b0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                out_idx_next   = cur_reg;
                out_box_next   = hold_reg;
                pend_next      = 1'b1;
                picked_next    = picked_reg + 1'b1;
                j_next         = k_reg;
                wait_next      = 3'd0;
                if (picks_reg != '0 && picked_reg + 1'b1 >= picks_reg)
                    state_next = S_DONE;
                else
                    state_next = S_SJ;
            end
            S_SJ:
            begin
                // next suppression target in rank order
                if ({1'b0, j_reg} + 1'b1 >= ncand_reg)
                begin
                    if ({1'b0, k_reg} + 1'b1 >= ncand_reg)
                        state_next = S_DONE;
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        wait_next  = 3'd0;
                        state_next = S_PRD;
                    end
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    ord_raddr  = j_reg + 1'b1;
                    wait_next  = 3'd0;
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                ord_raddr = j_reg;
                if (wait_reg == 3'd0)
                    wait_next = 3'd1;
                else
                begin
                    i_next     = ord_rdata;
                    box_raddr  = ord_rdata;
                    wait_next  = 3'd0;
                    state_next = S_SCMP;
                end
            end
            S_SCMP:
            begin
                box_raddr = i_reg;
                if (wait_reg == 3'd0)
                    wait_next = 3'd1;
                else if (wait_reg == 3'd1)
                    wait_next = 3'd2;
                else
                begin
                    if (!keep)
                        alive_next[i_reg] = 1'b0;
                    state_next = S_SJ;
                end
            end
            S_DONE:
            begin
                // release the held word as the last pick, then wait for it
                if (pend_reg)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    pend_next      = 1'b0;
                end
                else if (!out_valid_reg || m_axis_tready)
                begin
                    state_next  = S_LOAD;
                    picked_next = '0;
                    count_next  = '0;
                    alive_next  = '0;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            picked_reg    <= '0;
            alive_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cur_reg       <= '0;
            rank_reg      <= '0;
            ncand_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            picked_reg    <= picked_next;
            alive_reg     <= alive_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            pend_reg      <= pend_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            cur_reg       <= cur_next;
            rank_reg      <= rank_next;
            ncand_reg     <= ncand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg    <= hold_next;
        out_idx_reg <= out_idx_next;
        out_box_reg <= out_box_next;
    end

endmodule
